@@ hdl/tea_pkg.sv @@
// Shared constants, types and helpers for the TEA block cipher core.
// No dependencies; every other file imports this package.

package tea_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned ROUNDS    = 32;
   // One pipeline stage per half round
   localparam int unsigned STAGES    = 2 * ROUNDS;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

   localparam logic [WORD_W-1:0] KEY_0_RESET = 32'd5678123;
   localparam logic [WORD_W-1:0] KEY_1_RESET = 32'd21673;
   localparam logic [WORD_W-1:0] KEY_2_RESET = 32'd656172392;
   localparam logic [WORD_W-1:0] KEY_3_RESET = 32'd9872;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_0 = 8'd0,
      CSR_KEY_1 = 8'd1,
      CSR_KEY_2 = 8'd2,
      CSR_KEY_3 = 8'd3
   } tea_csr_type;

   typedef struct packed {
      logic [WORD_W-1:0] k0;
      logic [WORD_W-1:0] k1;
      logic [WORD_W-1:0] k2;
      logic [WORD_W-1:0] k3;
   } tea_key_type;

   // Block in flight: mode bit and both halves
   typedef struct packed {
      logic              decrypt;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } tea_data_type;

   // Round sum after n additions of the delta, mod 2^32 (elaboration only)
   function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
      logic [2*WORD_W-1:0] prod;
      prod = (2*WORD_W)'(n) * (2*WORD_W)'(TEA_DELTA);
      return prod[WORD_W-1:0];
   endfunction

endpackage

@@ hdl/tea_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on tea_pkg for the word width.

interface tea_req_if import tea_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [WORD_W-1:0] block_lo;
   logic [WORD_W-1:0] block_hi;

   modport source (output valid, command, block_lo, block_hi, input ready);
   modport sink   (input valid, command, block_lo, block_hi, output ready);
endinterface

interface tea_rsp_if import tea_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] out_lo;
   logic [WORD_W-1:0] out_hi;

   modport source (output valid, out_lo, out_hi, input ready);
   modport sink   (input valid, out_lo, out_hi, output ready);
endinterface

@@ hdl/tea_stage.sv @@
// One half-round pipeline stage of the TEA core: updates one half of the block.
// Depends on tea_pkg. Sums and stage parity arrive as constant inputs.

module tea_stage import tea_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              odd_half,
   input  logic [WORD_W-1:0] enc_sum,
   input  logic [WORD_W-1:0] dec_sum,
   input  tea_key_type       keys,
   input  logic              in_valid,
   input  tea_data_type      in_data,
   output logic              valid_ff,
   output tea_data_type      data_ff
);

   logic              upd_a;
   logic [WORD_W-1:0] x;
   logic [WORD_W-1:0] ka;
   logic [WORD_W-1:0] kb;
   logic [WORD_W-1:0] sum;
   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] target;
   logic [WORD_W-1:0] result;
   tea_data_type      data_in;

   // Encrypt: even stage updates a, odd updates b. Decrypt is the mirror.
   always_comb begin
      upd_a  = (odd_half == in_data.decrypt);
      x      = upd_a ? in_data.b : in_data.a;
      ka     = upd_a ? keys.k0 : keys.k2;
      kb     = upd_a ? keys.k1 : keys.k3;
      sum    = in_data.decrypt ? dec_sum : enc_sum;
      mix    = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
      target = upd_a ? in_data.a : in_data.b;
      result = in_data.decrypt ? (target - mix) : (target + mix);
      data_in = in_data;
      if (upd_a) begin
         data_in.a = result;
      end else begin
         data_in.b = result;
      end
   end

   // Valid bit cleared by reset; payload just moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ hdl/tea_block_cipher_core.sv @@
// Top level of the TEA block cipher core: key registers, round pipeline, output skid.
// Depends on tea_pkg, tea_if (tea_req_if, tea_rsp_if) and tea_stage.
//
// Usage:
//  - req_chan carries one item per handshake: command (0 encrypt, 1 decrypt)
//    and the 64-bit block as block_lo / block_hi. rsp_chan returns one item,
//    out_lo / out_hi, per request, in request order.
//  - Keys are written through csr_write_en / csr_index / csr_write_data,
//    index 0..3 for key words 0..3; other indexes are ignored. Write keys only
//    while no item is in flight.
//  - Throughput: one item per cycle while the output buffer is not full. Each item
//    passes 64 half-round stages (two per round, one add-xor-add each) and then
//    the output register before rsp_chan.valid.
//  - Reset (synchronous, active high) empties the pipeline and the output
//    buffer and loads the default key words.
//  - When the receiver stalls, a two-entry output buffer holds finished items;
//    the pipeline keeps accepting while the buffer has room and freezes in
//    place, without loss, once it is full and rsp_chan.ready is low.

module tea_block_cipher_core import tea_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tea_req_if.sink              req_chan,
   tea_rsp_if.source            rsp_chan,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data
);

   localparam logic [1:0] CNT_EMPTY = 2'd0;
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_FULL  = 2'd2;

   tea_key_type  keys_ff, keys_in;
   logic         stage_valid [0:STAGES];
   tea_data_type stage_data  [0:STAGES];
   logic         advance;
   logic         push;
   logic         pop;
   logic [1:0]   count_ff, count_in;
   tea_data_type head_ff, head_in;
   tea_data_type skid_ff, skid_in;

   // Key register writes
   always_comb begin
      keys_in = keys_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_KEY_0: keys_in.k0 = csr_write_data;
            CSR_KEY_1: keys_in.k1 = csr_write_data;
            CSR_KEY_2: keys_in.k2 = csr_write_data;
            CSR_KEY_3: keys_in.k3 = csr_write_data;
            default:   keys_in    = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '{k0: KEY_0_RESET, k1: KEY_1_RESET, k2: KEY_2_RESET, k3: KEY_3_RESET};
      end else begin
         keys_ff <= keys_in;
      end
   end

   // Whole pipeline moves while the output buffer can take an item
   assign advance        = (count_ff != CNT_FULL) || rsp_chan.ready;
   assign req_chan.ready = advance;

   assign stage_valid[0]        = req_chan.valid;
   assign stage_data[0].decrypt = req_chan.command;
   assign stage_data[0].a       = req_chan.block_lo;
   assign stage_data[0].b       = req_chan.block_hi;

   // Half-round stages; sums fixed per stage
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int unsigned RND = s / 2;
      tea_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .odd_half ((s % 2) == 1),
         .enc_sum  (round_sum(RND + 1)),
         .dec_sum  (round_sum(ROUNDS - RND)),
         .keys     (keys_ff),
         .in_valid (stage_valid[s]),
         .in_data  (stage_data[s]),
         .valid_ff (stage_valid[s+1]),
         .data_ff  (stage_data[s+1])
      );
   end

   // Two-entry output buffer: head drives the response, skid catches overflow
   assign push = advance && stage_valid[STAGES];
   assign pop  = (count_ff != CNT_EMPTY) && rsp_chan.ready;

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff;
      case (count_ff)
         CNT_EMPTY: begin
            if (push) begin
               head_in  = stage_data[STAGES];
               count_in = CNT_ONE;
            end
         end
         CNT_ONE: begin
            if (pop && push) begin
               head_in = stage_data[STAGES];
            end else if (pop) begin
               count_in = CNT_EMPTY;
            end else if (push) begin
               skid_in  = stage_data[STAGES];
               count_in = CNT_FULL;
            end
         end
         CNT_FULL: begin
            if (pop) begin
               head_in = skid_ff;
               if (push) begin
                  skid_in = stage_data[STAGES];
               end else begin
                  count_in = CNT_ONE;
               end
            end
         end
         default: count_in = CNT_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_EMPTY;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid  = (count_ff != CNT_EMPTY);
   assign rsp_chan.out_lo = head_ff.a;
   assign rsp_chan.out_hi = head_ff.b;

endmodule

@@ hdl/tea_checker.sv @@
// Port-level checks for the TEA block cipher core, attached by bind.
// Depends on tea_pkg and tea_if.

module tea_checker import tea_pkg::*; (
   input logic       clock,
   input logic       reset,
   tea_req_if.sink   req_chan,
   tea_rsp_if.source rsp_chan
);

   // Nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

   // An empty output side never blocks new items
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled with no response pending");

   // A draining receiver keeps the input open
   a_ready_follows_sink: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("input stalled while receiver is ready");

   // Stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.out_lo) && $stable(rsp_chan.out_hi))
      else $error("stalled response changed");

endmodule

bind tea_block_cipher_core tea_checker u_tea_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for tea_block_cipher_core: random blocks in both modes under several keys.
// Depends on tea_pkg and the tea_req_if / tea_rsp_if channel interfaces.

module tb_top;
   import tea_pkg::*;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   // Indexes outside the key map; writes to them must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 8'hFF;

   localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam int unsigned DRAIN_CYCLES  = 2 * STAGES + 10;
   localparam int unsigned PHASE_ITEMS   = 300;

   typedef struct packed {
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
   } cipher_out_type;

   logic clock;
   logic reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_write_data;

   tea_req_if req_bus ();
   tea_rsp_if rsp_bus ();

   tea_block_cipher_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Bench copy of the key registers
   tea_key_type key_copy;

   tea_data_type   pending_blocks[$];
   cipher_out_type expected_blocks[$];

   int unsigned fail_count;
   int unsigned enc_count;
   int unsigned dec_count;
   int unsigned key_settings;
   bit          quiet;
   int unsigned send_gap;
   int unsigned recv_stall;

   // One half-round mix term
   function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] x,
                                                 input logic [WORD_W-1:0] sum,
                                                 input logic [WORD_W-1:0] ka,
                                                 input logic [WORD_W-1:0] kb);
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

   // Full cipher transform of one block under the given key
   function automatic cipher_out_type tea_transform(input tea_data_type blk,
                                                    input tea_key_type key);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] sum;
      cipher_out_type    res;
      a = blk.a;
      b = blk.b;
      if (blk.decrypt == CMD_ENCRYPT) begin
         sum = '0;
         for (int r = 0; r < ROUNDS; r++) begin
            sum = sum + TEA_DELTA;
            a = a + tea_mix(b, sum, key.k0, key.k1);
            b = b + tea_mix(a, sum, key.k2, key.k3);
         end
      end else begin
         sum = WORD_W'(TEA_DELTA * ROUNDS);
         for (int r = 0; r < ROUNDS; r++) begin
            b = b - tea_mix(a, sum, key.k2, key.k3);
            a = a - tea_mix(b, sum, key.k0, key.k1);
            sum = sum - TEA_DELTA;
         end
      end
      res.lo = a;
      res.hi = b;
      return res;
   endfunction

   function automatic tea_data_type make_block(input logic cmd, input logic [WORD_W-1:0] lo,
                                               input logic [WORD_W-1:0] hi);
      tea_data_type blk;
      blk.decrypt = cmd;
      blk.a       = lo;
      blk.b       = hi;
      return blk;
   endfunction

   function automatic logic [WORD_W-1:0] edge_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return 32'h8000_0000;
         3:       return 32'h0000_0001;
         4:       return 32'hAAAA_AAAA;
         default: return $urandom();
      endcase
   endfunction

   // Queue a block, then queue the opposite operation on its predicted output
   task automatic push_round_trip(input logic cmd, input logic [WORD_W-1:0] lo,
                                  input logic [WORD_W-1:0] hi);
      cipher_out_type fwd;
      fwd = tea_transform(make_block(cmd, lo, hi), key_copy);
      pending_blocks.push_back(make_block(cmd, lo, hi));
      pending_blocks.push_back(make_block(~cmd, fwd.lo, fwd.hi));
   endtask

   // Register write; only called with the pipeline empty
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_KEY_0: key_copy.k0 = data;
         CSR_KEY_1: key_copy.k1 = data;
         CSR_KEY_2: key_copy.k2 = data;
         CSR_KEY_3: key_copy.k3 = data;
         default:   ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_key(input tea_key_type key);
      csr_write(CSR_KEY_0, key.k0);
      csr_write(CSR_KEY_1, key.k1);
      csr_write(CSR_KEY_2, key.k2);
      csr_write(CSR_KEY_3, key.k3);
      key_settings++;
   endtask

   // Wait until every queued item is sent and every result is back
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_blocks.size() != 0 || req_bus.valid || expected_blocks.size() != 0);
   endtask

   task automatic fill_random(input int unsigned count);
      int unsigned n;
      n = 0;
      while (n < count) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               push_round_trip(1'($urandom_range(0, 1)), $urandom(), $urandom());
               n += 2;
            end
            2, 3: begin
               pending_blocks.push_back(make_block(1'($urandom_range(0, 1)), edge_word(),
                                                   edge_word()));
               n++;
            end
            default: begin
               pending_blocks.push_back(make_block(1'($urandom_range(0, 1)), $urandom(),
                                                   $urandom()));
               n++;
            end
         endcase
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Known input values from time zero
   initial begin
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_write_data  = '0;
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_ENCRYPT;
      req_bus.block_lo = '0;
      req_bus.block_hi = '0;
      rsp_bus.ready    = 1'b0;
   end

   // Request driver: pops pending items, inserts random idle bursts
   always @(posedge clock) begin : req_driver
      tea_data_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_blocks.push_back(tea_transform(
               make_block(req_bus.command, req_bus.block_lo, req_bus.block_hi), key_copy));
            if (req_bus.command == CMD_ENCRYPT)
               enc_count++;
            else
               dec_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               send_gap      <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               send_gap      <= $urandom_range(0, 4);
               req_bus.valid <= 1'b0;
            end else if (pending_blocks.size() != 0) begin
               nxt = pending_blocks.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.command  <= nxt.decrypt;
               req_bus.block_lo <= nxt.a;
               req_bus.block_hi <= nxt.b;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver backpressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall    <= 0;
      end else if (recv_stall != 0) begin
         recv_stall    <= recv_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         recv_stall    <= $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Result monitor: compare against the oldest expected block
   always @(posedge clock) begin : rsp_monitor
      cipher_out_type exp_blk;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected result item: out_lo %h out_hi %h", rsp_bus.out_lo,
                   rsp_bus.out_hi);
            fail_count++;
         end else begin
            exp_blk = expected_blocks.pop_front();
            if (rsp_bus.out_lo !== exp_blk.lo) begin
               $error("out_lo mismatch: expected %h, got %h", exp_blk.lo, rsp_bus.out_lo);
               fail_count++;
            end
            if (rsp_bus.out_hi !== exp_blk.hi) begin
               $error("out_hi mismatch: expected %h, got %h", exp_blk.hi, rsp_bus.out_hi);
               fail_count++;
            end
         end
      end
   end

   // Stimulus sequence
   initial begin : stimulus
      tea_key_type key;
      key_copy.k0 = 32'd5678123;
      key_copy.k1 = 32'd21673;
      key_copy.k2 = 32'd656172392;
      key_copy.k3 = 32'd9872;
      quiet = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed blocks under the reset key
      pending_blocks.push_back(make_block(CMD_ENCRYPT, '0, '0));
      pending_blocks.push_back(make_block(CMD_DECRYPT, '0, '0));
      pending_blocks.push_back(make_block(CMD_ENCRYPT, ALL_ONES, ALL_ONES));
      pending_blocks.push_back(make_block(CMD_DECRYPT, ALL_ONES, ALL_ONES));
      pending_blocks.push_back(make_block(CMD_ENCRYPT, ALL_ONES, '0));
      pending_blocks.push_back(make_block(CMD_DECRYPT, '0, ALL_ONES));
      pending_blocks.push_back(make_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001));
      pending_blocks.push_back(make_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000));
      pending_blocks.push_back(make_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555));
      pending_blocks.push_back(make_block(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA));
      push_round_trip(CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
      push_round_trip(CMD_DECRYPT, 32'hDEAD_BEEF, 32'hCAFE_F00D);
      wait_drained();

      // Writes to unmapped indexes must leave the key alone
      csr_write(CSR_UNMAPPED_LO, ALL_ONES);
      csr_write(CSR_UNMAPPED_HI, 32'h1234_5678);
      push_round_trip(CMD_ENCRYPT, '0, '0);
      pending_blocks.push_back(make_block(CMD_ENCRYPT, ALL_ONES, ALL_ONES));
      fill_random(PHASE_ITEMS / 2);
      wait_drained();

      // All-zero key
      key = '0;
      load_key(key);
      pending_blocks.push_back(make_block(CMD_ENCRYPT, '0, '0));
      fill_random(PHASE_ITEMS);
      wait_drained();

      // All-ones key
      key = '1;
      load_key(key);
      pending_blocks.push_back(make_block(CMD_DECRYPT, ALL_ONES, ALL_ONES));
      fill_random(PHASE_ITEMS);
      wait_drained();

      // Random key, plus a stray write to a random unmapped index
      key.k0 = $urandom();
      key.k1 = $urandom();
      key.k2 = $urandom();
      key.k3 = $urandom();
      load_key(key);
      csr_write(CSR_IDX_W'($urandom_range(CSR_UNMAPPED_LO, CSR_UNMAPPED_HI)), $urandom());
      fill_random(PHASE_ITEMS);
      wait_drained();

      // Single-bit and alternating key words
      key.k0 = 32'h0000_0001;
      key.k1 = 32'h8000_0000;
      key.k2 = 32'hAAAA_AAAA;
      key.k3 = 32'h5555_5555;
      load_key(key);
      fill_random(PHASE_ITEMS);
      wait_drained();

      // Another random key
      key.k0 = $urandom();
      key.k1 = $urandom();
      key.k2 = $urandom();
      key.k3 = $urandom();
      load_key(key);
      fill_random(PHASE_ITEMS);
      wait_drained();

      // Last stretch at full rate, back to the default key words
      quiet  = 1'b1;
      key.k0 = 32'd5678123;
      key.k1 = 32'd21673;
      key.k2 = 32'd656172392;
      key.k3 = 32'd9872;
      load_key(key);
      fill_random(PHASE_ITEMS / 2);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d encrypt and %0d decrypt items over %0d key settings,",
               enc_count, dec_count, key_settings + 1);
      $display("with unmapped register writes and random idling on both channels.");
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("Timeout with %0d results outstanding", expected_blocks.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
